// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file e2r_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define E2R_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define E2R_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// Types, constants and rounding helper for the Euler angle rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package e2r_pkg;

  localparam int ANGLE_WIDTH  = 16;
  localparam int COEF_WIDTH   = 16;
  localparam int QBITS        = 30;
  localparam int CORDIC_STEPS = 30;
  localparam int ANGLE_SHIFT  = QBITS - (ANGLE_WIDTH - 4);
  localparam int TW           = 36;
  localparam int XW           = 34;
  localparam int SCW          = 32;
  localparam int PW           = 64;
  localparam int ENW          = 34;

  localparam logic signed [TW-1:0] Q_PI      = 36'sh0C90FDAA2;
  localparam logic signed [TW-1:0] Q_HALF_PI = 36'sh06487ED51;
  localparam logic signed [TW-1:0] Q_TWO_PI  = 36'sh1921FB544;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic signed [PW-1:0] ROUND_HALF  = 64'sd536870912;
  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(2 ** (COEF_WIDTH - 2));

  localparam logic signed [TW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
    36'sh03243F6A8, 36'sh01DAC6705, 36'sh00FADBAFC, 36'sh007F56EA6, 36'sh003FEAB76,
    36'sh001FFD55B, 36'sh000FFFAAA, 36'sh0007FFF55, 36'sh0003FFFEA, 36'sh0001FFFFD,
    36'sh0000FFFFF, 36'sh00007FFFF, 36'sh00003FFFF, 36'sh00001FFFF, 36'sh00000FFFF,
    36'sh000007FFF, 36'sh000003FFF, 36'sh000001FFF, 36'sh000000FFF, 36'sh0000007FF,
    36'sh0000003FF, 36'sh0000001FF, 36'sh0000000FF, 36'sh00000007F, 36'sh00000003F,
    36'sh00000001F, 36'sh00000000F, 36'sh000000008, 36'sh000000004, 36'sh000000002
  };

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] azimuth_angle;
    logic signed [ANGLE_WIDTH-1:0] elevation_angle;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] r00;
    logic signed [COEF_WIDTH-1:0] r01;
    logic signed [COEF_WIDTH-1:0] r02;
    logic signed [COEF_WIDTH-1:0] r10;
    logic signed [COEF_WIDTH-1:0] r11;
    logic signed [COEF_WIDTH-1:0] r12;
    logic signed [COEF_WIDTH-1:0] r20;
    logic signed [COEF_WIDTH-1:0] r21;
    logic signed [COEF_WIDTH-1:0] r22;
  } matrix_t;

  typedef struct packed {
    logic signed [SCW-1:0] sin_v;
    logic signed [SCW-1:0] cos_v;
  } sincos_t;

  function automatic logic signed [SCW-1:0] round_q(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = (p + ROUND_HALF) >>> QBITS;
    return s[SCW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: src/e2r_cordic.sv
// ----------------------------------------------------------------------------
// e2r_cordic
// Pipelined sine/cosine: range reduction, one rotation per stage, sign fix.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_cordic (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    en_i,
  input  wire logic                                    valid_i,
  input  wire logic signed [e2r_pkg::ANGLE_WIDTH-1:0]  angle_i,
  output logic                                         valid_o,
  output e2r_pkg::sincos_t                             sc_o
);

  localparam int N = e2r_pkg::CORDIC_STEPS;

  logic signed [e2r_pkg::TW-1:0] t_raw;
  logic signed [e2r_pkg::TW-1:0] wrap_d, wrap_q;
  logic signed [e2r_pkg::TW-1:0] red_d;
  logic                          flip_d;
  logic                          vwrap_q;
  logic                          vout_q;
  logic signed [e2r_pkg::TW-1:0] t_q [N+1];
  logic signed [e2r_pkg::XW-1:0] x_q [N+1];
  logic signed [e2r_pkg::XW-1:0] y_q [N+1];
  logic                          flip_q [N+1];
  logic                          v_q [N+1];
  logic signed [e2r_pkg::XW-1:0] xn, yn;
  e2r_pkg::sincos_t              sc_q;

  assign t_raw = {{(e2r_pkg::TW - e2r_pkg::ANGLE_WIDTH){angle_i[e2r_pkg::ANGLE_WIDTH-1]}},
                  angle_i} <<< e2r_pkg::ANGLE_SHIFT;

  always_comb begin
    if (t_raw > e2r_pkg::Q_PI) begin
      wrap_d = t_raw - e2r_pkg::Q_TWO_PI;
    end else if (t_raw < -e2r_pkg::Q_PI) begin
      wrap_d = t_raw + e2r_pkg::Q_TWO_PI;
    end else begin
      wrap_d = t_raw;
    end
  end

  always_comb begin
    if (wrap_q > e2r_pkg::Q_HALF_PI) begin
      red_d  = wrap_q - e2r_pkg::Q_PI;
      flip_d = 1'b1;
    end else if (wrap_q < -e2r_pkg::Q_HALF_PI) begin
      red_d  = wrap_q + e2r_pkg::Q_PI;
      flip_d = 1'b1;
    end else begin
      red_d  = wrap_q;
      flip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vwrap_q <= 1'b0;
      v_q[0]  <= 1'b0;
    end else if (en_i) begin
      vwrap_q <= valid_i;
      v_q[0]  <= vwrap_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wrap_q    <= wrap_d;
      t_q[0]    <= red_d;
      flip_q[0] <= flip_d;
      x_q[0]    <= e2r_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (t_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          t_q[i+1] <= t_q[i] - e2r_pkg::ATAN_Q30[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          t_q[i+1] <= t_q[i] + e2r_pkg::ATAN_Q30[i];
        end
      end
    end
  end

  assign xn = flip_q[N] ? -x_q[N] : x_q[N];
  assign yn = flip_q[N] ? -y_q[N] : y_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q.sin_v <= yn[e2r_pkg::SCW-1:0];
      sc_q.cos_v <= xn[e2r_pkg::SCW-1:0];
    end
  end

  assign valid_o = vout_q;
  assign sc_o    = sc_q;

  // t_q of the last stage is the residual angle and is not needed further
  logic unused_t;
  assign unused_t = ^t_q[N];

endmodule

`default_nettype wire

// File: src/e2r_mat.sv
// ----------------------------------------------------------------------------
// e2r_mat
// Pipelined products, sums and output rounding of the nine matrix entries.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_mat (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  e2r_pkg::sincos_t       az_i,
  input  e2r_pkg::sincos_t       el_i,
  input  e2r_pkg::sincos_t       ro_i,
  output logic                   valid_o,
  output e2r_pkg::matrix_t       mat_o
);

  localparam int SH = e2r_pkg::QBITS - (e2r_pkg::COEF_WIDTH - 2);
  localparam logic signed [e2r_pkg::ENW-1:0] HALF = e2r_pkg::ENW'((2 ** SH) / 2);
  localparam logic signed [e2r_pkg::ENW-1:0] ONE  =
    e2r_pkg::ENW'(2 ** (e2r_pkg::COEF_WIDTH - 2));

  // product order: ca*se, sa*se, ca*ce, sa*ce, ce*sr, ce*cr, sa*cr, ca*cr, sa*sr, ca*sr
  logic signed [e2r_pkg::PW-1:0]  p1_q [10];
  logic signed [e2r_pkg::SCW-1:0] r2_q [10];
  logic signed [e2r_pkg::SCW-1:0] se1_q, se2_q, se3_q;
  logic signed [e2r_pkg::PW-1:0]  p3_q [4];
  logic signed [e2r_pkg::SCW-1:0] k3_q [8];
  logic signed [e2r_pkg::ENW-1:0] ent_d [9];
  logic signed [e2r_pkg::ENW-1:0] ent_q [9];
  logic signed [e2r_pkg::SCW-1:0] t4 [4];
  logic signed [e2r_pkg::ENW-1:0] rnd [9];
  logic signed [e2r_pkg::ENW-1:0] clp [9];
  logic [4:0]                     v_q;
  e2r_pkg::matrix_t               mat_q;
  logic signed [e2r_pkg::SCW-1:0] sr1_q, sr2_q, cr1_q, cr2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q[0] <= az_i.cos_v * el_i.sin_v;
      p1_q[1] <= az_i.sin_v * el_i.sin_v;
      p1_q[2] <= az_i.cos_v * el_i.cos_v;
      p1_q[3] <= az_i.sin_v * el_i.cos_v;
      p1_q[4] <= el_i.cos_v * ro_i.sin_v;
      p1_q[5] <= el_i.cos_v * ro_i.cos_v;
      p1_q[6] <= az_i.sin_v * ro_i.cos_v;
      p1_q[7] <= az_i.cos_v * ro_i.cos_v;
      p1_q[8] <= az_i.sin_v * ro_i.sin_v;
      p1_q[9] <= az_i.cos_v * ro_i.sin_v;
      se1_q   <= el_i.sin_v;
      se2_q   <= se1_q;
      se3_q   <= se2_q;
      for (int i = 0; i < 10; i++) begin
        r2_q[i] <= e2r_pkg::round_q(p1_q[i]);
      end
      p3_q[0] <= r2_q[0] * sr2_q;
      p3_q[1] <= r2_q[0] * cr2_q;
      p3_q[2] <= r2_q[1] * sr2_q;
      p3_q[3] <= r2_q[1] * cr2_q;
      for (int i = 0; i < 8; i++) begin
        k3_q[i] <= r2_q[i+2];
      end
      ent_q <= ent_d;
      mat_q.r00 <= clp[0][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r01 <= clp[1][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r02 <= clp[2][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r10 <= clp[3][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r11 <= clp[4][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r12 <= clp[5][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r20 <= clp[6][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r21 <= clp[7][e2r_pkg::COEF_WIDTH-1:0];
      mat_q.r22 <= clp[8][e2r_pkg::COEF_WIDTH-1:0];
    end
  end

  // roll sine and cosine delayed to meet the rounded first products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr1_q <= ro_i.sin_v;
      cr1_q <= ro_i.cos_v;
      sr2_q <= sr1_q;
      cr2_q <= cr1_q;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      t4[i] = e2r_pkg::round_q(p3_q[i]);
    end
    // k3_q: ca*ce, sa*ce, ce*sr, ce*cr, sa*cr, ca*cr, sa*sr, ca*sr
    ent_d[0] = e2r_pkg::ENW'(k3_q[0]);
    ent_d[1] = e2r_pkg::ENW'(k3_q[1]);
    ent_d[2] = -e2r_pkg::ENW'(se3_q);
    ent_d[3] = e2r_pkg::ENW'(t4[0]) - e2r_pkg::ENW'(k3_q[4]);
    ent_d[4] = e2r_pkg::ENW'(t4[2]) + e2r_pkg::ENW'(k3_q[5]);
    ent_d[5] = e2r_pkg::ENW'(k3_q[2]);
    ent_d[6] = e2r_pkg::ENW'(t4[1]) + e2r_pkg::ENW'(k3_q[6]);
    ent_d[7] = e2r_pkg::ENW'(t4[3]) - e2r_pkg::ENW'(k3_q[7]);
    ent_d[8] = e2r_pkg::ENW'(k3_q[3]);
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      rnd[i] = (ent_q[i] + HALF) >>> SH;
      if (rnd[i] > ONE) begin
        clp[i] = ONE;
      end else if (rnd[i] < -ONE) begin
        clp[i] = -ONE;
      end else begin
        clp[i] = rnd[i];
      end
    end
  end

  assign valid_o = v_q[4];
  assign mat_o   = mat_q;

endmodule

`default_nettype wire

// File: src/e2r_skid.sv
// ----------------------------------------------------------------------------
// e2r_skid
// Output register with one skid entry; drives the pipeline advance enable.
// ----------------------------------------------------------------------------
`default_nettype none

module e2r_skid (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  e2r_pkg::matrix_t    data_i,
  output logic                en_o,
  output logic                valid_o,
  input  wire logic           stall_i,
  output e2r_pkg::matrix_t    data_o
);

  logic             out_v_q, skid_v_q;
  e2r_pkg::matrix_t out_q, skid_q;
  logic             take;

  assign take = out_v_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (valid_i) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q && take) begin
      out_q <= skid_q;
    end else if (!skid_v_q && valid_i && (!out_v_q || take)) begin
      out_q <= data_i;
    end
    if (!skid_v_q && valid_i && out_v_q && !take) begin
      skid_q <= data_i;
    end
  end

  assign en_o    = !skid_v_q;
  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// File: src/euler_to_rotation_matrix_top.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_top
// Azimuth/elevation/roll (Q4.12 rad) to the 3x3 ZYX rotation block (Q1.14).
// ----------------------------------------------------------------------------
// One orientation is taken per cycle while in_stall_o is low and each gives
// one matrix through 33 stages of CORDIC (two range-reduction stages, one
// rotation per stage over 30 stages, one sign stage), five stages of multiply,
// round, sum and clamp, and one output register. The three angles run through
// their own CORDIC pipes side by side. A skid entry behind the output register
// lets the pipe take one more item while a result waits; in_stall_o rises only
// once that entry is full.
`default_nettype none

module euler_to_rotation_matrix_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  e2r_pkg::angles_t   in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output e2r_pkg::matrix_t   out_data_o
);

  logic             en;
  logic             v_az, v_el, v_ro, v_mat;
  e2r_pkg::sincos_t sc_az, sc_el, sc_ro;
  e2r_pkg::matrix_t mat;

  e2r_cordic u_cordic_az (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .angle_i(in_data_i.azimuth_angle), .valid_o(v_az), .sc_o(sc_az)
  );

  e2r_cordic u_cordic_el (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .angle_i(in_data_i.elevation_angle), .valid_o(v_el), .sc_o(sc_el)
  );

  e2r_cordic u_cordic_ro (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i),
    .angle_i(in_data_i.roll_angle), .valid_o(v_ro), .sc_o(sc_ro)
  );

  e2r_mat u_mat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_az && v_el && v_ro),
    .az_i(sc_az), .el_i(sc_el), .ro_i(sc_ro), .valid_o(v_mat), .mat_o(mat)
  );

  e2r_skid u_skid (
    .clk_i, .rst_ni, .valid_i(v_mat), .data_i(mat), .en_o(en),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .data_o(out_data_o)
  );

  assign in_stall_o = !en;

endmodule

`default_nettype wire

// File: src/e2r_checker.sv
// ----------------------------------------------------------------------------
// e2r_checker
// Port-level checks on the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module e2r_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input e2r_pkg::angles_t       in_data_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input e2r_pkg::matrix_t       out_data_o
);

  logic unused_in;
  logic out_hold;
  logic r02_ok;

  assign unused_in = in_valid_i ^ (^in_data_i);
  assign out_hold  = out_valid_o && out_stall_i;
  assign r02_ok    = (out_data_o.r02 <= e2r_pkg::COEF_ONE) &&
                     (out_data_o.r02 >= -e2r_pkg::COEF_ONE);

  `E2R_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_hold, out_valid_o && $stable(out_data_o))
  `E2R_ASSERT_NOW(a_stall_needs_out, clk_i, rst_ni, in_stall_o, out_valid_o)
  `E2R_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_hold))
  `E2R_ASSERT_NOW(a_r02_range, clk_i, rst_ni, out_valid_o, r02_ok)

endmodule

bind euler_to_rotation_matrix_top e2r_checker u_e2r_checker (.*);

`default_nettype wire
